[hdl/sih_pkg.sv]
`timescale 1ns / 1ps
package sih_pkg;

  localparam int SLOTS_LOG2  = 10;
  localparam int MAX_KEY_LEN = 64;
  localparam int STORE_BYTES = 16384;
  localparam int SLOT_DEPTH  = 1 << SLOTS_LOG2;

  localparam int IDX_W  = SLOTS_LOG2;          // slot index
  localparam int CNT_W  = SLOTS_LOG2 + 1;      // slot count / entry count
  localparam int LEN_W  = 7;                   // key length 0..64
  localparam int BUF_AW = 6;                   // key buffer address
  localparam int ST_AW  = 14;                  // key store address
  localparam int TOP_W  = 15;                  // store top 0..16384
  localparam int LG_W   = 4;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] FUNC_INTERN = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [2:0] ST_FOUND      = 3'd0;
  localparam logic [2:0] ST_INSERTED   = 3'd1;
  localparam logic [2:0] ST_ABSENT     = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_STORE_FULL = 3'd4;
  localparam logic [2:0] ST_TOO_LONG   = 3'd5;
  localparam logic [2:0] ST_CLEARED    = 3'd6;

  localparam logic REG_SLOT_LOG2   = 1'b0;
  localparam logic REG_ARENA_LIMIT = 1'b1;

  typedef struct packed {
    logic             used;
    logic [31:0]      hash;
    logic [LEN_W-1:0] len;
    logic [ST_AW-1:0] off;
  } slot_t;

  typedef struct packed {
    logic       in_acc;      // fold a key byte
    logic       key_clr;
    logic       table_clr;
    logic       sweep_step;
    logic       probe_init;
    logic       probe_next;
    logic       slot_rd;
    logic       i_clr;
    logic       i_inc;
    logic       cmp_rd;
    logic       cp_rd;
    logic       cp_wr;
    logic       insert;
    logic       pend_load;
    logic [2:0] pend_code;
    logic       pend_found;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic too_long;
    logic slot_used;
    logic slot_match;
    logic len_zero;
    logic byte_eq;
    logic i_last;
    logic probe_last;
    logic fits;
    logic out_free;
  } sts_t;

endpackage

[hdl/sih_datapath.sv]
`timescale 1ns / 1ps
module sih_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          key_byte,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [14:0]         cfg_data,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [39:0]         out_tdata,
  input  sih_pkg::cmd_t       cmd,
  output sih_pkg::sts_t       sts
);

  sih_pkg::slot_t slot_mem [sih_pkg::SLOT_DEPTH];
  logic [7:0] store_mem [sih_pkg::STORE_BYTES];
  logic [7:0] kbuf_mem [sih_pkg::MAX_KEY_LEN];

  logic [sih_pkg::LG_W-1:0]  lg_cfg_r;
  logic [14:0]               lim_cfg_r;
  logic [31:0]               hash_r;
  logic [sih_pkg::LEN_W-1:0] len_r;
  logic                      too_long_r;
  logic [sih_pkg::CNT_W-1:0] entries_r;
  logic [sih_pkg::TOP_W-1:0] top_r;
  logic [sih_pkg::IDX_W-1:0] sweep_r;
  logic [sih_pkg::IDX_W-1:0] idx_r;
  logic [sih_pkg::CNT_W-1:0] probe_r;
  logic [sih_pkg::LEN_W-1:0] i_r;
  sih_pkg::slot_t            slot_q;
  logic [7:0]                kbuf_q;
  logic [7:0]                store_q;
  logic [2:0]                pend_code_r;
  logic [sih_pkg::ST_AW-1:0] pend_handle_r;
  logic [sih_pkg::IDX_W-1:0] pend_slot_r;
  logic                      out_valid_r;
  logic [39:0]               out_data_r;

  logic [sih_pkg::LG_W-1:0]  lg_c;
  logic [sih_pkg::CNT_W-1:0] slots;
  logic [sih_pkg::IDX_W-1:0] mask;
  logic [sih_pkg::TOP_W-1:0] lim;
  logic [sih_pkg::TOP_W:0]   need;
  logic [31:0]               hash_nxt;
  logic [sih_pkg::ST_AW-1:0] st_waddr;
  logic [7:0]                st_wdata;

  always_comb begin
    if (lg_cfg_r == '0) begin
      lg_c = sih_pkg::LG_W'(1);
    end else if (lg_cfg_r > sih_pkg::LG_W'(sih_pkg::SLOTS_LOG2)) begin
      lg_c = sih_pkg::LG_W'(sih_pkg::SLOTS_LOG2);
    end else begin
      lg_c = lg_cfg_r;
    end
  end

  assign slots = sih_pkg::CNT_W'(1) << lg_c;
  assign mask  = sih_pkg::IDX_W'(slots - sih_pkg::CNT_W'(1));
  assign lim   = (lim_cfg_r > sih_pkg::TOP_W'(sih_pkg::STORE_BYTES)) ?
                 sih_pkg::TOP_W'(sih_pkg::STORE_BYTES) : lim_cfg_r;
  assign need  = {1'b0, top_r} + (sih_pkg::TOP_W+1)'(len_r) + (sih_pkg::TOP_W+1)'(1);
  assign hash_nxt = 32'((hash_r ^ {24'b0, key_byte}) * sih_pkg::FNV_PRIME);

  assign sts.sweep_last = (sweep_r == {sih_pkg::IDX_W{1'b1}});
  assign sts.too_long   = too_long_r;
  assign sts.slot_used  = slot_q.used;
  assign sts.slot_match = (slot_q.hash == hash_r) && (slot_q.len == len_r) &&
                          ((15'(slot_q.off) + 15'(len_r)) <= 15'(sih_pkg::STORE_BYTES));
  assign sts.len_zero   = (len_r == '0);
  assign sts.byte_eq    = (kbuf_q == store_q);
  assign sts.i_last     = (sih_pkg::LEN_W'(i_r + sih_pkg::LEN_W'(1)) == len_r);
  assign sts.probe_last = ((probe_r + sih_pkg::CNT_W'(1)) == slots);
  assign sts.fits       = (need <= {1'b0, lim});
  assign sts.out_free   = !out_valid_r || out_tready;

  // store write: key bytes during copy, terminator on insert
  always_comb begin
    if (cmd.insert) begin
      st_waddr = top_r[sih_pkg::ST_AW-1:0] + sih_pkg::ST_AW'(len_r);
      st_wdata = 8'h00;
    end else begin
      st_waddr = top_r[sih_pkg::ST_AW-1:0] + sih_pkg::ST_AW'(i_r);
      st_wdata = kbuf_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      slot_mem[sweep_r] <= '0;
    end else if (cmd.insert) begin
      slot_mem[idx_r] <= '{used: 1'b1, hash: hash_r, len: len_r,
                           off: top_r[sih_pkg::ST_AW-1:0]};
    end
    if (cmd.slot_rd) begin
      slot_q <= slot_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cp_wr || cmd.insert) begin
      store_mem[st_waddr] <= st_wdata;
    end
    if (cmd.cmp_rd) begin
      store_q <= store_mem[slot_q.off + sih_pkg::ST_AW'(i_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_acc && (len_r < sih_pkg::LEN_W'(sih_pkg::MAX_KEY_LEN))) begin
      kbuf_mem[len_r[sih_pkg::BUF_AW-1:0]] <= key_byte;
    end
    if (cmd.cmp_rd || cmd.cp_rd) begin
      kbuf_q <= kbuf_mem[i_r[sih_pkg::BUF_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_cfg_r    <= sih_pkg::LG_W'(10);
      lim_cfg_r   <= 15'd16384;
      hash_r      <= sih_pkg::FNV_BASIS;
      len_r       <= '0;
      too_long_r  <= 1'b0;
      entries_r   <= '0;
      top_r       <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == sih_pkg::REG_SLOT_LOG2) begin
          lg_cfg_r <= cfg_data[sih_pkg::LG_W-1:0];
        end else begin
          lim_cfg_r <= cfg_data;
        end
      end
      if (cmd.key_clr) begin
        hash_r     <= sih_pkg::FNV_BASIS;
        len_r      <= '0;
        too_long_r <= 1'b0;
      end else if (cmd.in_acc) begin
        hash_r <= hash_nxt;
        if (len_r < sih_pkg::LEN_W'(sih_pkg::MAX_KEY_LEN)) begin
          len_r <= len_r + sih_pkg::LEN_W'(1);
        end else begin
          too_long_r <= 1'b1;
        end
      end
      if (cmd.table_clr) begin
        entries_r <= '0;
        top_r     <= '0;
        sweep_r   <= '0;
      end else begin
        if (cmd.sweep_step) begin
          sweep_r <= sweep_r + sih_pkg::IDX_W'(1);
        end
        if (cmd.insert) begin
          entries_r <= entries_r + sih_pkg::CNT_W'(1);
          top_r     <= need[sih_pkg::TOP_W-1:0];
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      idx_r   <= hash_r[sih_pkg::IDX_W-1:0] & mask;
      probe_r <= '0;
    end else if (cmd.probe_next) begin
      idx_r   <= (idx_r + sih_pkg::IDX_W'(1)) & mask;
      probe_r <= probe_r + sih_pkg::CNT_W'(1);
    end
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + sih_pkg::LEN_W'(1);
    end
    if (cmd.insert) begin
      pend_code_r   <= sih_pkg::ST_INSERTED;
      pend_handle_r <= top_r[sih_pkg::ST_AW-1:0];
      pend_slot_r   <= idx_r;
    end else if (cmd.pend_load) begin
      pend_code_r   <= cmd.pend_code;
      pend_handle_r <= cmd.pend_found ? slot_q.off : '0;
      pend_slot_r   <= cmd.pend_found ? idx_r : '0;
    end
    if (cmd.out_load) begin
      out_data_r <= {2'b00, entries_r, pend_slot_r, pend_handle_r, pend_code_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/sih_ctrl.sv]
`timescale 1ns / 1ps
module sih_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    func,
  input  logic          has_byte,
  input  logic          last_byte,
  input  sih_pkg::sts_t sts,
  output sih_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_START, S_PROBE_RD, S_PROBE_CHK, S_CMP_RD, S_CMP_CHK,
    S_CP_RD, S_CP_WR, S_INSERT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   lookup_r, lookup_nxt;
  logic   clr_pend_r, clr_pend_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    lookup_nxt   = lookup_r;
    clr_pend_nxt = clr_pend_r;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt    = clr_pend_r ? S_EMIT : S_IDLE;
          clr_pend_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (func == sih_pkg::FUNC_CLEAR) begin
            cmd.table_clr = 1'b1;
            cmd.key_clr   = 1'b1;
            cmd.pend_load = 1'b1;
            cmd.pend_code = sih_pkg::ST_CLEARED;
            clr_pend_nxt  = 1'b1;
            state_nxt     = S_SWEEP;
          end else if (func == sih_pkg::FUNC_INTERN || func == sih_pkg::FUNC_LOOKUP) begin
            cmd.in_acc = has_byte;
            if (last_byte) begin
              lookup_nxt = (func == sih_pkg::FUNC_LOOKUP);
              state_nxt  = S_START;
            end
          end
        end
      end
      S_START: begin
        if (sts.too_long) begin
          cmd.pend_load = 1'b1;
          cmd.pend_code = sih_pkg::ST_TOO_LONG;
          state_nxt     = S_EMIT;
        end else begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (!sts.slot_used) begin
          if (lookup_r) begin
            cmd.pend_load = 1'b1;
            cmd.pend_code = sih_pkg::ST_ABSENT;
            state_nxt     = S_EMIT;
          end else if (!sts.fits) begin
            cmd.pend_load = 1'b1;
            cmd.pend_code = sih_pkg::ST_STORE_FULL;
            state_nxt     = S_EMIT;
          end else begin
            cmd.i_clr = 1'b1;
            state_nxt = sts.len_zero ? S_INSERT : S_CP_RD;
          end
        end else if (sts.slot_match) begin
          if (sts.len_zero) begin
            cmd.pend_load  = 1'b1;
            cmd.pend_code  = sih_pkg::ST_FOUND;
            cmd.pend_found = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            cmd.i_clr = 1'b1;
            state_nxt = S_CMP_RD;
          end
        end else if (sts.probe_last) begin
          cmd.pend_load = 1'b1;
          cmd.pend_code = lookup_r ? sih_pkg::ST_ABSENT : sih_pkg::ST_TABLE_FULL;
          state_nxt     = S_EMIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_nxt  = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (!sts.byte_eq) begin
          if (sts.probe_last) begin
            cmd.pend_load = 1'b1;
            cmd.pend_code = lookup_r ? sih_pkg::ST_ABSENT : sih_pkg::ST_TABLE_FULL;
            state_nxt     = S_EMIT;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = S_PROBE_RD;
          end
        end else if (sts.i_last) begin
          cmd.pend_load  = 1'b1;
          cmd.pend_code  = sih_pkg::ST_FOUND;
          cmd.pend_found = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_CMP_RD;
        end
      end
      S_CP_RD: begin
        cmd.cp_rd = 1'b1;
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.cp_wr = 1'b1;
        cmd.i_inc = 1'b1;
        state_nxt = sts.i_last ? S_INSERT : S_CP_RD;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.key_clr  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      lookup_r   <= 1'b0;
      clr_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lookup_r   <= lookup_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

endmodule

[hdl/string_intern_hash_table.sv]
`timescale 1ns / 1ps
// String intern table, FNV-1a hashed, linearly probed.
// in_*: up to one key byte per transfer. tdata = key_byte, tuser = {has_byte,
//   func}; tlast ends a key. func of the tlast transfer picks intern (0) or
//   lookup (1); func 2 clears the table at once, func 3 is dropped.
// out_*: one transfer per completed key or clear: status, key_handle,
//   slot_index, entry_count packed from bit 0 up.
// cfg_*: register write channel, always ready; index 0 slot_count_log2,
//   index 1 arena_limit. Write only while the block is idle.
// Sequence: non-final key bytes are taken one per cycle while the block is idle.
//   A completed key then steps through accept and start, a read and a check
//   per probed slot, a read and a check per compared byte on a hash/length hit,
//   a read and a write per byte copied and the slot write on insert, then the
//   post. These steps are set by the single-port slot table and key store walks.
// Reset and clear: the slot table is swept, one slot a cycle, across all 1024
//   slots while in_tready stays low; the cleared result posts after the sweep.
// Output stall: the result register holds; the block waits in its post step
//   only when a new result is ready and the previous one is still untaken.
module string_intern_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] key_byte
  input  logic [2:0]  in_tuser,   // [1:0] func, [2] has_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] status, [16:3] key_handle,
                                  // [26:17] slot_index, [37:27] entry_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  sih_pkg::cmd_t cmd;
  sih_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sih_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .func      (in_tuser[1:0]),
    .has_byte  (in_tuser[2]),
    .last_byte (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  sih_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_byte   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[test/string_intern_hash_table_tb.sv]
`timescale 1ns / 1ps
module string_intern_hash_table_tb;

  typedef struct packed {
    logic [2:0]                status;
    logic [sih_pkg::ST_AW-1:0] handle;
    logic [sih_pkg::IDX_W-1:0] slot;
    logic [sih_pkg::CNT_W-1:0] count;
  } intern_result_t;

  localparam logic [1:0] FUNC_NONE = 2'd3;  // unused code, dropped by the block
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [14:0] cfg_data = '0;

  string_intern_hash_table dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block: slot table, key store, key in flight, registers
  logic                      tbl_used [sih_pkg::SLOT_DEPTH];
  logic [31:0]               tbl_hash [sih_pkg::SLOT_DEPTH];
  logic [sih_pkg::LEN_W-1:0] tbl_len  [sih_pkg::SLOT_DEPTH];
  logic [sih_pkg::ST_AW-1:0] tbl_off  [sih_pkg::SLOT_DEPTH];
  logic [7:0]                store_mem [sih_pkg::STORE_BYTES];
  int                        store_used;
  int                        live_keys;
  logic [7:0]                key_bytes [sih_pkg::MAX_KEY_LEN];
  logic [31:0]               key_hash;
  int                        key_len;
  logic                      key_overflow;
  logic [3:0]                reg_slot_log2;
  logic [14:0]               reg_arena;

  intern_result_t results_due[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int status_hits [8];
  bit stall_on = 1'b1;
  int cycles = 0;

  // pool of keys so that repeats and lookups hit
  logic [7:0] pool_bytes [40][72];
  int         pool_len [40];

  task automatic post_result(input logic [2:0] st, input int h, input int s);
    intern_result_t r;
    r.status = st;
    r.handle = h[sih_pkg::ST_AW-1:0];
    r.slot   = s[sih_pkg::IDX_W-1:0];
    r.count  = live_keys[sih_pkg::CNT_W-1:0];
    results_due.push_back(r);
  endtask

  task automatic reset_key();
    key_hash = sih_pkg::FNV_BASIS;
    key_len = 0;
    key_overflow = 1'b0;
  endtask

  task automatic empty_table();
    for (int i = 0; i < sih_pkg::SLOT_DEPTH; i++) tbl_used[i] = 1'b0;
    store_used = 0;
    live_keys = 0;
  endtask

  task automatic resolve_key(input bit lookup);
    int lg, slots, idx, lim, off;
    bit eq;
    if (key_overflow) begin
      reset_key();
      post_result(sih_pkg::ST_TOO_LONG, 0, 0);
      return;
    end
    lg = reg_slot_log2;
    if (lg < 1) lg = 1;
    if (lg > sih_pkg::SLOTS_LOG2) lg = sih_pkg::SLOTS_LOG2;
    slots = 1 << lg;
    idx = key_hash & (slots - 1);
    lim = (reg_arena > sih_pkg::STORE_BYTES) ? sih_pkg::STORE_BYTES : reg_arena;
    for (int p = 0; p < slots; p++) begin
      if (!tbl_used[idx]) begin
        if (lookup) begin
          post_result(sih_pkg::ST_ABSENT, 0, 0);
        end else if (store_used + key_len + 1 > lim) begin
          post_result(sih_pkg::ST_STORE_FULL, 0, 0);
        end else begin
          off = store_used;
          for (int j = 0; j < key_len; j++) store_mem[off + j] = key_bytes[j];
          store_mem[off + key_len] = 8'h00;
          store_used = off + key_len + 1;
          tbl_used[idx] = 1'b1;
          tbl_hash[idx] = key_hash;
          tbl_len[idx]  = key_len[sih_pkg::LEN_W-1:0];
          tbl_off[idx]  = off[sih_pkg::ST_AW-1:0];
          live_keys++;
          post_result(sih_pkg::ST_INSERTED, off, idx);
        end
        reset_key();
        return;
      end
      if (tbl_hash[idx] == key_hash && tbl_len[idx] == key_len[sih_pkg::LEN_W-1:0]) begin
        eq = 1'b1;
        for (int j = 0; j < key_len; j++)
          if (store_mem[tbl_off[idx] + j] != key_bytes[j]) eq = 1'b0;
        if (eq) begin
          post_result(sih_pkg::ST_FOUND, tbl_off[idx], idx);
          reset_key();
          return;
        end
      end
      idx = (idx + 1) & (slots - 1);
    end
    post_result(lookup ? sih_pkg::ST_ABSENT : sih_pkg::ST_TABLE_FULL, 0, 0);
    reset_key();
  endtask

  // one accepted input transfer through the shadow
  task automatic model_transfer(input logic [1:0] f, input logic [7:0] b,
                                input logic hb, input logic lb);
    if (f == FUNC_NONE) return;
    if (f == sih_pkg::FUNC_CLEAR) begin
      empty_table();
      reset_key();
      post_result(sih_pkg::ST_CLEARED, 0, 0);
      return;
    end
    if (hb) begin
      key_hash = (key_hash ^ {24'd0, b}) * sih_pkg::FNV_PRIME;
      if (key_len < sih_pkg::MAX_KEY_LEN) begin
        key_bytes[key_len] = b;
        key_len++;
      end else begin
        key_overflow = 1'b1;
      end
    end
    if (lb) resolve_key(f == sih_pkg::FUNC_LOOKUP);
  endtask

  // sender: valid stays up across back-to-back transfers
  task automatic send_item(input logic [1:0] f, input logic [7:0] b,
                           input logic hb, input logic lb);
    if (stall_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = {hb, f};
    in_tlast  = lb;
    do @(posedge clk); while (!in_tready);
    model_transfer(f, b, hb, lb);
    items_sent++;
    @(negedge clk);
  endtask

  // key from the pool; func of non-final bytes is intern or lookup at random
  task automatic send_pool_key(input logic [1:0] f, input int k);
    int n;
    n = pool_len[k];
    if (n == 0) begin
      send_item(f, 8'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 30) == 0)
        send_item(2'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b0);
      if (i > 0 && $urandom_range(0, 40) == 0)
        send_item(FUNC_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      send_item((i == n - 1) ? f : 2'($urandom_range(0, 1)), pool_bytes[k][i], 1'b1,
                i == n - 1);
    end
  endtask

  task automatic set_pool_key(input int k, input int n, input int alpha);
    pool_len[k] = n;
    for (int i = 0; i < n; i++)
      pool_bytes[k][i] = (alpha == 0) ? 8'($urandom) : 8'($urandom_range(97, 96 + alpha));
  endtask

  // block idle: every result back, then a margin of idle clocks
  task automatic drain();
    in_tvalid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [14:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sih_pkg::REG_SLOT_LOG2) reg_slot_log2 = val[3:0];
    else reg_arena = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result side: random stall bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (!stall_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    intern_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transfer %h", out_tdata);
        errors++;
      end else begin
        exp_r = results_due.pop_front();
        results_seen++;
        status_hits[exp_r.status]++;
        if (out_tdata[2:0] !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[16:3] !== exp_r.handle) begin
          $error("key_handle: expected %0d, got %0d", exp_r.handle, out_tdata[16:3]);
          errors++;
        end
        if (out_tdata[26:17] !== exp_r.slot) begin
          $error("slot_index: expected %0d, got %0d", exp_r.slot, out_tdata[26:17]);
          errors++;
        end
        if (out_tdata[37:27] !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, out_tdata[37:27]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", results_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // empty key, byte extremes, repeats, lookups, dropped func, clear mid-key,
  // byte-less middle transfer, longest key and one byte over
  task automatic test_directed();
    send_item(sih_pkg::FUNC_INTERN, 8'h00, 1'b0, 1'b1);
    send_item(sih_pkg::FUNC_INTERN, 8'h00, 1'b0, 1'b1);
    send_item(sih_pkg::FUNC_LOOKUP, 8'hFF, 1'b0, 1'b1);
    send_item(sih_pkg::FUNC_LOOKUP, 8'hFF, 1'b1, 1'b1);
    send_item(sih_pkg::FUNC_INTERN, 8'hFF, 1'b1, 1'b1);
    send_item(sih_pkg::FUNC_INTERN, 8'h00, 1'b1, 1'b1);
    send_item(sih_pkg::FUNC_LOOKUP, 8'hFF, 1'b1, 1'b1);
    send_item(FUNC_NONE, 8'hA5, 1'b1, 1'b1);
    send_item(sih_pkg::FUNC_INTERN, 8'h41, 1'b1, 1'b0);
    send_item(sih_pkg::FUNC_LOOKUP, 8'h00, 1'b0, 1'b0);
    send_item(sih_pkg::FUNC_INTERN, 8'h42, 1'b1, 1'b1);
    send_item(sih_pkg::FUNC_INTERN, 8'h43, 1'b1, 1'b0);
    send_item(sih_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0);
    send_item(sih_pkg::FUNC_LOOKUP, 8'h00, 1'b0, 1'b1);
    set_pool_key(0, 64, 0);
    send_pool_key(sih_pkg::FUNC_INTERN, 0);
    send_pool_key(sih_pkg::FUNC_LOOKUP, 0);
    set_pool_key(1, 65, 0);
    send_pool_key(sih_pkg::FUNC_INTERN, 1);
  endtask

  // two slots: third key finds the table full, lookup walks both slots
  task automatic test_table_full();
    write_reg(sih_pkg::REG_SLOT_LOG2, 15'd1);
    send_item(sih_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b1);
    for (int k = 2; k < 6; k++) set_pool_key(k, $urandom_range(1, 4), 0);
    for (int k = 2; k < 6; k++) send_pool_key(sih_pkg::FUNC_INTERN, k);
    for (int k = 2; k < 6; k++) send_pool_key(sih_pkg::FUNC_LOOKUP, k);
    write_reg(sih_pkg::REG_SLOT_LOG2, 15'd0);
    send_pool_key(sih_pkg::FUNC_INTERN, 5);
    send_item(sih_pkg::FUNC_INTERN, 8'h00, 1'b0, 1'b1);
    write_reg(sih_pkg::REG_SLOT_LOG2, 15'h7FFF);
    send_pool_key(sih_pkg::FUNC_INTERN, 5);
  endtask

  // store limits: zero, tight, above the store size
  task automatic test_store_full();
    write_reg(sih_pkg::REG_ARENA_LIMIT, 15'd0);
    send_item(sih_pkg::FUNC_INTERN, 8'h00, 1'b0, 1'b1);
    send_item(sih_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b1);
    write_reg(sih_pkg::REG_ARENA_LIMIT, 15'd1);
    send_item(sih_pkg::FUNC_INTERN, 8'h10, 1'b1, 1'b1);
    send_item(sih_pkg::FUNC_INTERN, 8'h00, 1'b0, 1'b1);
    send_item(sih_pkg::FUNC_INTERN, 8'h11, 1'b0, 1'b1);
    write_reg(sih_pkg::REG_ARENA_LIMIT, 15'h7FFF);
    send_item(sih_pkg::FUNC_INTERN, 8'h10, 1'b1, 1'b1);
  endtask

  // random phases over several table sizes and store limits
  task automatic test_random();
    int lg_pick [8] = '{1, 2, 3, 4, 6, 10, 0, 15};
    int arena_pick [6] = '{16384, 32767, 300, 80, 16383, 1};
    int k, mark;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) stall_on = 1'b0;
      write_reg(sih_pkg::REG_SLOT_LOG2, 15'(lg_pick[ph]));
      write_reg(sih_pkg::REG_ARENA_LIMIT, 15'(arena_pick[$urandom_range(0, 5)]));
      send_item(sih_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
      for (int i = 0; i < 40; i++)
        set_pool_key(i, ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                        : $urandom_range(0, 6), $urandom_range(0, 1) ? 0 : 3);
      mark = items_sent;
      while (items_sent - mark < 210) begin
        k = $urandom_range(0, 39);
        case ($urandom_range(0, 19))
          0:       send_item(sih_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom),
                             1'($urandom));
          1:       send_item(FUNC_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
          2, 3, 4: send_pool_key(sih_pkg::FUNC_LOOKUP, k);
          default: send_pool_key(sih_pkg::FUNC_INTERN, k);
        endcase
      end
    end
  endtask

  initial begin
    empty_table();
    reset_key();
    reg_slot_log2 = 4'd10;
    reg_arena = 15'd16384;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    // reset sweep keeps in_tready low
    while (!in_tready) @(negedge clk);
    test_directed();
    test_table_full();
    test_store_full();
    test_random();
    drain();
    repeat (50) @(negedge clk);
    $display("%0d transfers in, %0d results checked over 8 table/store settings",
             items_sent, results_seen);
    $display("found %0d inserted %0d absent %0d tfull %0d sfull %0d long %0d clr %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
